FILE: sv/crcc_pkg.sv
// Shared types, codes and the CRC-32 byte update for the chunk receiver.
package crcc_pkg;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int FIFO_DEPTH = 4;
	localparam int CAP_W = 13;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	localparam logic [1:0] FUNC_BEGIN = 2'd0;
	localparam logic [1:0] FUNC_DATA  = 2'd1;
	localparam logic [1:0] FUNC_END   = 2'd2;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_RECV   = 2'd1;
	localparam logic [1:0] PH_STORED = 2'd2;
	localparam logic [1:0] PH_ERROR  = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SIZE   = 3'd1;
	localparam logic [2:0] ST_OFFSET = 3'd2;
	localparam logic [2:0] ST_STATE  = 3'd3;
	localparam logic [2:0] ST_CRC    = 3'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic        size_bad;
		logic [15:0] xfer_size;
		logic [31:0] expected_crc;
		logic [15:0] vendor_id;
		logic [15:0] product_id;
		logic [15:0] chunk_offset;
		logic        len_zero;
		logic [16:0] chunk_end;
		logic [7:0]  data_byte;
		logic        chunk_first;
		logic        chunk_last;
	} cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: sv/crcc_ram.sv
// Generic single-port-write RAM with a registered read port.
module crcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: sv/crcc_front.sv
// Front end: capacity register, word decode and the checks that need no transfer state.
module crcc_front import crcc_pkg::*; #(
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [1:0]       func,
	input  logic [15:0]      xfer_size,
	input  logic [31:0]      expected_crc,
	input  logic [15:0]      vendor_id,
	input  logic [15:0]      product_id,
	input  logic [15:0]      chunk_offset,
	input  logic [15:0]      chunk_len,
	input  logic [7:0]       data_byte,
	input  logic             chunk_first,
	input  logic             chunk_last,
	output logic             push,
	output cmd_t             push_cmd
);

	logic [CAP_W-1:0] capacity_q;
	logic [16:0]      cap_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if ({4'd0, capacity_q} > 17'(STORE_BYTES)) begin
			cap_eff = 17'(STORE_BYTES);
		end else begin
			cap_eff = {4'd0, capacity_q};
		end
	end

	// The unused function code has no effect and is dropped here.
	assign push = in_valid && !in_stall &&
		(func == FUNC_BEGIN || func == FUNC_DATA || func == FUNC_END);

	always_comb begin
		push_cmd.func         = func;
		push_cmd.size_bad     = (xfer_size == 16'd0) || ({1'b0, xfer_size} > cap_eff);
		push_cmd.xfer_size    = xfer_size;
		push_cmd.expected_crc = expected_crc;
		push_cmd.vendor_id    = vendor_id;
		push_cmd.product_id   = product_id;
		push_cmd.chunk_offset = chunk_offset;
		push_cmd.len_zero     = (chunk_len == 16'd0);
		push_cmd.chunk_end    = {1'b0, chunk_offset} + {1'b0, chunk_len};
		push_cmd.data_byte    = data_byte;
		push_cmd.chunk_first  = chunk_first;
		push_cmd.chunk_last   = chunk_last;
	end

endmodule

FILE: sv/crcc_fifo.sv
// Short command queue between the front end and the back end.
module crcc_fifo import crcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output cmd_t head
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	cmd_t          mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full     = (count_q == CW'(FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: sv/crcc_back.sv
// Back end: transfer state, running CRC, byte store writes and the result register.
module crcc_back import crcc_pkg::*; #(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cmd_t          cmd,
	output logic          cmd_pop,
	output logic          st_wr_en,
	output logic [AW-1:0] st_wr_addr,
	output logic [7:0]    st_wr_data,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    status,
	output logic [1:0]    machine_state,
	output logic [15:0]   bytes_received,
	output logic [15:0]   stored_vendor_id,
	output logic [15:0]   stored_product_id
);

	logic [1:0]  phase_q, phase_n;
	logic [15:0] total_q, total_n;
	logic [31:0] ann_crc_q, ann_crc_n;
	logic [31:0] crc_q, crc_n;
	logic [15:0] count_q, count_n;
	logic [15:0] vendor_q, vendor_n;
	logic [15:0] product_q, product_n;
	logic        open_q, open_n;
	logic [16:0] limit_q, limit_n;
	logic        res;
	logic [2:0]  res_status;
	logic        first_bad;
	logic [16:0] limit_use;
	logic        out_valid_q;

	assign cmd_pop   = cmd_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign first_bad = cmd.len_zero || (cmd.chunk_offset != count_q) ||
		(cmd.chunk_end > {1'b0, total_q});
	assign limit_use = cmd.chunk_first ? cmd.chunk_end : limit_q;

	always_comb begin
		phase_n    = phase_q;
		total_n    = total_q;
		ann_crc_n  = ann_crc_q;
		crc_n      = crc_q;
		count_n    = count_q;
		vendor_n   = vendor_q;
		product_n  = product_q;
		open_n     = open_q;
		limit_n    = limit_q;
		res        = 1'b0;
		res_status = ST_OK;
		st_wr_en   = 1'b0;
		unique case (cmd.func)
			FUNC_BEGIN: begin
				res    = 1'b1;
				open_n = 1'b0;
				if (cmd.size_bad) begin
					phase_n    = PH_ERROR;
					res_status = ST_SIZE;
				end else begin
					total_n   = cmd.xfer_size;
					ann_crc_n = cmd.expected_crc;
					vendor_n  = cmd.vendor_id;
					product_n = cmd.product_id;
					count_n   = '0;
					crc_n     = CRC_INIT;
					phase_n   = PH_RECV;
				end
			end
			FUNC_DATA: begin
				if (phase_q != PH_RECV) begin
					res        = 1'b1;
					res_status = ST_STATE;
				end else if (cmd.chunk_first && first_bad) begin
					phase_n    = PH_ERROR;
					open_n     = 1'b0;
					res        = 1'b1;
					res_status = ST_OFFSET;
				end else if (!cmd.chunk_first && !open_q) begin
					res        = 1'b1;
					res_status = ST_STATE;
				end else begin
					limit_n = limit_use;
					if (({1'b0, count_q} >= limit_use) ||
						({1'b0, count_q} >= 17'(STORE_BYTES))) begin
						phase_n    = PH_ERROR;
						open_n     = 1'b0;
						res        = 1'b1;
						res_status = ST_OFFSET;
					end else begin
						st_wr_en = 1'b1;
						crc_n    = crc_byte(crc_q, cmd.data_byte);
						count_n  = count_q + 16'd1;
						open_n   = !cmd.chunk_last;
						res      = cmd.chunk_last;
					end
				end
			end
			FUNC_END: begin
				res = 1'b1;
				if (phase_q != PH_RECV) begin
					res_status = ST_STATE;
				end else begin
					open_n = 1'b0;
					if ((count_q != total_q) || ((crc_q ^ CRC_INIT) != ann_crc_q)) begin
						phase_n    = PH_ERROR;
						res_status = ST_CRC;
					end else begin
						phase_n = PH_STORED;
					end
				end
			end
			default: begin
			end
		endcase
		st_wr_en = st_wr_en && cmd_pop;
	end

	assign st_wr_addr = count_q[AW-1:0];
	assign st_wr_data = cmd.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			total_q   <= '0;
			ann_crc_q <= '0;
			crc_q     <= CRC_INIT;
			count_q   <= '0;
			vendor_q  <= '0;
			product_q <= '0;
			open_q    <= 1'b0;
			limit_q   <= '0;
		end else if (cmd_pop) begin
			phase_q   <= phase_n;
			total_q   <= total_n;
			ann_crc_q <= ann_crc_n;
			crc_q     <= crc_n;
			count_q   <= count_n;
			vendor_q  <= vendor_n;
			product_q <= product_n;
			open_q    <= open_n;
			limit_q   <= limit_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_pop && res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && res) begin
			status            <= res_status;
			machine_state     <= phase_n;
			bytes_received    <= count_n;
			stored_vendor_id  <= vendor_n;
			stored_product_id <= product_n;
		end
	end

endmodule

FILE: sv/crc_checked_chunk_receiver.sv
// Top level of the CRC-checked chunk receiver.
// The receiver takes one word per cycle while in_stall is low: begin, data byte or end of a
// sized transfer. Words are decoded and size-checked in the front end, then wait in a
// four-entry queue; the back end takes one word per cycle from the queue unless out_stall
// holds a waiting result, folds a data byte into the CRC-32 and writes it to the byte store
// in that same cycle, and loads a result into the output register. in_stall rises only when
// the queue is full, which happens only while out_stall holds a waiting result. The byte store
// needs no clearing after reset, so words are taken from the first cycle on.
module crc_checked_chunk_receiver import crcc_pkg::*; #(
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	input  logic [15:0]      xfer_size,
	input  logic [31:0]      expected_crc,
	input  logic [15:0]      vendor_id,
	input  logic [15:0]      product_id,
	input  logic [15:0]      chunk_offset,
	input  logic [15:0]      chunk_len,
	input  logic [7:0]       data_byte,
	input  logic             chunk_first,
	input  logic             chunk_last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [1:0]       machine_state,
	output logic [15:0]      bytes_received,
	output logic [15:0]      stored_vendor_id,
	output logic [15:0]      stored_product_id
);

	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	logic          nonempty;
	cmd_t          head;
	logic          st_wr_en;
	logic [AW-1:0] st_wr_addr;
	logic [7:0]    st_wr_data;

	crcc_front #(.STORE_BYTES(STORE_BYTES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.xfer_size    (xfer_size),
		.expected_crc (expected_crc),
		.vendor_id    (vendor_id),
		.product_id   (product_id),
		.chunk_offset (chunk_offset),
		.chunk_len    (chunk_len),
		.data_byte    (data_byte),
		.chunk_first  (chunk_first),
		.chunk_last   (chunk_last),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	crcc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (in_stall),
		.nonempty (nonempty),
		.head     (head)
	);

	crcc_back #(.STORE_BYTES(STORE_BYTES)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (nonempty),
		.cmd               (head),
		.cmd_pop           (pop),
		.st_wr_en          (st_wr_en),
		.st_wr_addr        (st_wr_addr),
		.st_wr_data        (st_wr_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.machine_state     (machine_state),
		.bytes_received    (bytes_received),
		.stored_vendor_id  (stored_vendor_id),
		.stored_product_id (stored_product_id)
	);

	crcc_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_addr ('0),
		.rd_data ()
	);

endmodule

FILE: sv/crcc_checker.sv
// Port-level checker for the chunk receiver and its bind to the top level.
module crcc_checker import crcc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [1:0]  machine_state,
	input logic [15:0] bytes_received
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(machine_state))
		else $error("stalled result changed");

	a_fail_to_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SIZE || status == ST_OFFSET || status == ST_CRC)
		|-> machine_state == PH_ERROR)
		else $error("failing status without error phase");

	a_ok_not_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> machine_state != PH_ERROR)
		else $error("ok status in error phase");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && machine_state == PH_IDLE |-> bytes_received == 16'd0)
		else $error("bytes counted while idle");

endmodule

bind crc_checked_chunk_receiver crcc_checker u_crcc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.machine_state  (machine_state),
	.bytes_received (bytes_received)
);
